// ===== hdl/rtprc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtprc_pkg;

	localparam int DEPTH_DEF   = 64;
	localparam int STREAMS_DEF = 16;

	localparam logic [6:0] CAPACITY_RESET = 7'd64;
	localparam logic [2:0] REG_CAPACITY_ADDR = 3'd0;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_FIND  = 2'd1,
		CMD_ERASE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_EMPTY     = 3'd1,
		STATUS_CAP_ZERO  = 3'd2,
		STATUS_HDR_BAD   = 3'd3,
		STATUS_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  stream;
		logic [31:0] ssrc;
		logic [15:0] seq;
		logic [6:0]  ptype;
		logic        marker;
		logic [31:0] timestamp;
		logic        header_ok;
		logic [15:0] packet_handle;
		logic [15:0] packet_len;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  out_stream;
		logic [31:0] out_ssrc;
		logic [15:0] out_seq;
		logic [6:0]  out_ptype;
		logic        out_marker;
		logic [31:0] out_timestamp;
		logic [15:0] out_handle;
		logic [15:0] out_len;
		logic [6:0]  occupancy;
	} result_t;

	typedef struct packed {
		logic [3:0]  stream;
		logic [31:0] ssrc;
		logic [15:0] seq;
		logic [6:0]  ptype;
		logic        marker;
		logic [31:0] timestamp;
		logic [15:0] handle;
		logic [15:0] len;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PF_RD,
		ST_PF_DO,
		ST_ALLOC,
		ST_EV_CHK,
		ST_EV_RD,
		ST_EV_DO,
		ST_ER_A,
		ST_ER_B,
		ST_ER_C,
		ST_DONE
	} state_t;

	function automatic entry_t to_entry(item_t it);
		entry_t e;
		e.stream    = it.stream;
		e.ssrc      = it.ssrc;
		e.seq       = it.seq;
		e.ptype     = it.ptype;
		e.marker    = it.marker;
		e.timestamp = it.timestamp;
		e.handle    = it.packet_handle;
		e.len       = it.packet_len;
		return e;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rtprc_apb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtprc_apb
	import rtprc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [6:0]  capacity
);

	logic [6:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && paddr == REG_CAPACITY_ADDR) begin
			capacity_q <= pwdata[6:0];
		end
	end

	assign pready   = 1'b1;
	assign capacity = capacity_q;
	assign prdata   = (paddr == REG_CAPACITY_ADDR) ? {25'd0, capacity_q} : 32'd0;

endmodule
`default_nettype wire

// ===== hdl/rtp_retransmit_cache_fifo_evict.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Retransmission packet cache keyed by stream, SSRC and sequence number, with
// oldest-first eviction. A command is taken when start is high and busy is low;
// its single result appears on result for one cycle with done high and cannot be
// held off, so capture it then. Put and find walk the entry memory one slot per
// cycle; a put of a new key first drops the oldest entry when the table is full,
// then allocates a free slot and evicts oldest entries until the capacity is met;
// a put that overwrites stops its walk at the matching slot and then also evicts
// down to the capacity. Erase walks the age list entry by entry; clear and rejected
// puts go straight to the done state. done rises in the same cycle that busy falls.
// No clearing pass is needed after reset.
module rtp_retransmit_cache_fifo_evict
	import rtprc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             done,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7;

	function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	logic [6:0] capacity;

	rtprc_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// memories
	entry_t        ent_mem [DEPTH];
	logic [AW-1:0] age_mem [DEPTH];
	entry_t        ent_rd_q;
	logic [AW-1:0] age_rd_q;
	logic          ent_we, age_we;
	logic [AW-1:0] ent_wa, ent_ra, age_wa, age_ra, age_wd;
	entry_t        ent_wd;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		ent_rd_q <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
		age_rd_q <= age_mem[age_ra];
	end

	state_t          state_q, state_d;
	item_t           item_q;
	logic [DEPTH-1:0] valid_q;
	logic [CW-1:0]   count_q, er_n_q, lim;
	logic [AW-1:0]   head_q, tail_q, er_rd_q, er_wr_q, slot_q, idx_s1, free_idx;
	logic [CW-1:0]   idx_q;
	logic            chk_s1, hit, scan_issue;
	logic            done_q;
	result_t         res_q;

	assign lim = (CW'(capacity) < CW'(DEPTH)) ? CW'(capacity) : CW'(DEPTH);
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < CW'(DEPTH));
	assign hit = chk_s1 && valid_q[idx_s1] && ent_rd_q.stream == item_q.stream
		&& ent_rd_q.ssrc == item_q.ssrc && ent_rd_q.seq == item_q.seq;

	always_comb begin
		free_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = AW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ent_we  = 1'b0;
		ent_wa  = slot_q;
		ent_wd  = to_entry(item_q);
		ent_ra  = idx_q[AW-1:0];
		age_we  = 1'b0;
		age_wa  = tail_q;
		age_wd  = free_idx;
		age_ra  = head_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (item.cmd)
						CMD_PUT: begin
							if (item.packet_len == '0 || capacity == '0 || !item.header_ok)
								state_d = ST_DONE;
							else
								state_d = ST_SCAN;
						end
						CMD_FIND:  state_d = ST_SCAN;
						CMD_ERASE: state_d = ST_ER_A;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					if (item_q.cmd == CMD_PUT) begin
						ent_we  = 1'b1;
						ent_wa  = idx_s1;
						state_d = ST_EV_CHK;
					end else begin
						state_d = ST_DONE;
					end
				end else if (!scan_issue && !chk_s1) begin
					if (item_q.cmd != CMD_PUT)
						state_d = ST_DONE;
					else if (count_q >= CW'(DEPTH))
						state_d = ST_PF_RD;
					else
						state_d = ST_ALLOC;
				end
			end
			ST_PF_RD: state_d = ST_PF_DO;
			ST_PF_DO: state_d = ST_ALLOC;
			ST_ALLOC: begin
				ent_we  = 1'b1;
				ent_wa  = free_idx;
				age_we  = 1'b1;
				state_d = ST_EV_CHK;
			end
			ST_EV_CHK: state_d = (count_q > lim) ? ST_EV_RD : ST_DONE;
			ST_EV_RD:  state_d = ST_EV_DO;
			ST_EV_DO:  state_d = ST_EV_CHK;
			ST_ER_A: begin
				age_ra  = er_rd_q;
				state_d = (er_n_q == '0) ? ST_DONE : ST_ER_B;
			end
			ST_ER_B: begin
				ent_ra  = age_rd_q;
				state_d = ST_ER_C;
			end
			ST_ER_C: begin
				if (ent_rd_q.stream != item_q.stream) begin
					age_we = 1'b1;
					age_wa = er_wr_q;
					age_wd = slot_q;
				end
				state_d = ST_ER_A;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			chk_s1 <= scan_issue;
			case (state_q)
				ST_IDLE: begin
					if (start && item.cmd == CMD_CLEAR) begin
						valid_q <= '0;
						count_q <= '0;
						head_q  <= '0;
						tail_q  <= '0;
					end
				end
				ST_PF_DO, ST_EV_DO: begin
					valid_q[age_rd_q] <= 1'b0;
					count_q <= count_q - CW'(1);
					head_q  <= ptr_inc(head_q);
				end
				ST_ALLOC: begin
					valid_q[free_idx] <= 1'b1;
					count_q <= count_q + CW'(1);
					tail_q  <= ptr_inc(tail_q);
				end
				ST_ER_A: begin
					if (er_n_q == '0) tail_q <= er_wr_q;
				end
				ST_ER_C: begin
					if (ent_rd_q.stream == item_q.stream) begin
						valid_q[slot_q] <= 1'b0;
						count_q <= count_q - CW'(1);
					end
				end
				ST_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		if (scan_issue) idx_q <= idx_q + CW'(1);
		case (state_q)
			ST_IDLE: begin
				item_q <= item;
				idx_q  <= '0;
				er_rd_q <= head_q;
				er_wr_q <= head_q;
				er_n_q  <= count_q;
				res_q   <= '0;
				if (item.cmd == CMD_PUT) begin
					if (item.packet_len == '0)
						res_q.status <= STATUS_EMPTY;
					else if (capacity == '0)
						res_q.status <= STATUS_CAP_ZERO;
					else if (!item.header_ok)
						res_q.status <= STATUS_HDR_BAD;
				end
			end
			ST_SCAN: begin
				if (hit && item_q.cmd == CMD_FIND) begin
					res_q.out_stream    <= ent_rd_q.stream;
					res_q.out_ssrc      <= ent_rd_q.ssrc;
					res_q.out_seq       <= ent_rd_q.seq;
					res_q.out_ptype     <= ent_rd_q.ptype;
					res_q.out_marker    <= ent_rd_q.marker;
					res_q.out_timestamp <= ent_rd_q.timestamp;
					res_q.out_handle    <= ent_rd_q.handle;
					res_q.out_len       <= ent_rd_q.len;
				end else if (!hit && !scan_issue && !chk_s1 && item_q.cmd == CMD_FIND) begin
					res_q.status <= STATUS_NOT_FOUND;
				end else if (item_q.cmd == CMD_PUT) begin
					res_q.out_stream    <= item_q.stream;
					res_q.out_ssrc      <= item_q.ssrc;
					res_q.out_seq       <= item_q.seq;
					res_q.out_ptype     <= item_q.ptype;
					res_q.out_marker    <= item_q.marker;
					res_q.out_timestamp <= item_q.timestamp;
					res_q.out_handle    <= item_q.packet_handle;
					res_q.out_len       <= item_q.packet_len;
				end
			end
			ST_ER_B: slot_q <= age_rd_q;
			ST_ER_C: begin
				if (ent_rd_q.stream != item_q.stream) er_wr_q <= ptr_inc(er_wr_q);
				er_rd_q <= ptr_inc(er_rd_q);
				er_n_q  <= er_n_q - CW'(1);
			end
			ST_DONE: res_q.occupancy <= count_q[6:0];
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = res_q;

endmodule
`default_nettype wire
